// ===== hw/rtl/polygon_zone_locator_top_defines.svh =====
// Assertion macros used by the checker file.
`ifndef POLYGON_ZONE_LOCATOR_TOP_DEFINES_SVH
`define POLYGON_ZONE_LOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PZL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PZL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pzl_pkg.sv =====
package pzl_pkg;

  localparam int unsigned Fleets    = 8;
  localparam int unsigned Zones     = 32;
  localparam int unsigned MaxPoints = 16;
  localparam int unsigned CoordBits = 24;

  localparam int unsigned FleetW = 3;
  localparam int unsigned ZoneW  = 5;
  localparam int unsigned VtxW   = 4;
  localparam int unsigned CntW   = 5;   // holds MaxPoints itself
  localparam int unsigned SlotW  = FleetW + ZoneW;
  localparam int unsigned VAddrW = SlotW + VtxW;
  localparam int unsigned SumW   = CoordBits + VtxW;
  localparam int unsigned DiffW  = CoordBits + 1;
  localparam int unsigned ProdW  = 2 * DiffW;
  localparam int unsigned SqW    = 2 * CoordBits;
  localparam int unsigned DistW  = SqW + 1;
  localparam int unsigned InfoW  = CntW + 1;

  typedef enum logic [1:0] {
    REQ_VTX_WR = 2'd0,
    REQ_SET    = 2'd1,
    REQ_INSIDE = 2'd2,
    REQ_NEAR   = 2'd3
  } req_e;

  typedef enum logic [14:0] {
    S_IDLE    = 15'b000000000000001,
    S_SUM_RD  = 15'b000000000000010,
    S_SUM_ACC = 15'b000000000000100,
    S_DIV     = 15'b000000000001000,
    S_CWR     = 15'b000000000010000,
    S_ZRD     = 15'b000000000100000,
    S_ZCHK    = 15'b000000001000000,
    S_VRD     = 15'b000000010000000,
    S_VGET    = 15'b000000100000000,
    S_E1      = 15'b000001000000000,
    S_E2      = 15'b000010000000000,
    S_E3      = 15'b000100000000000,
    S_NSQ     = 15'b001000000000000,
    S_NCMP    = 15'b010000000000000,
    S_DONE    = 15'b100000000000000
  } state_e;

endpackage

// ===== hw/rtl/polygon_zone_locator_top.sv =====
// Polygon zone locator: per-fleet tables of zone polygons, searched by point.
// Command channel: present the fields and raise start while busy is low; the
// word is taken on that edge and busy stays high until the result is out.
// Result channel: done_o is high for exactly one cycle with zone_result_o and
// found_o; the receiver cannot stall it, so it must take the word then.
// One item is in flight at a time. A vertex write goes straight to done_o; a
// count/enable set sums the vertices and divides them for the centroid; a
// containing query visits zones 1 to 31 in order and walks the edges of each
// enabled zone of n >= 2 vertices until one holds the point; a nearest query
// visits every zone from 1 to 31.
// The edge test (subtract, multiply, compare, one stage each) and the single
// read port of the vertex memory set the containing-query time; the shared
// restoring divider (one quotient bit a cycle) sets the count-set time.
// Reset clears the sequencer and the per-zone valid bits, so every zone reads
// as absent with no vertices; no clearing pass is needed.
module polygon_zone_locator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [2:0]  fleet_sel_i,
  input  logic [4:0]  zone_sel_i,
  input  logic [3:0]  vertex_sel_i,
  input  logic [23:0] coord_x_i,
  input  logic [23:0] coord_y_i,
  input  logic [4:0]  vertex_total_i,
  input  logic        zone_enable_i,
  output logic        done_o,
  output logic [4:0]  zone_result_o,
  output logic        found_o
);

  localparam int unsigned CB = pzl_pkg::CoordBits;

  pzl_pkg::state_e state_q, state_d;

  logic                        accept;
  logic [1:0]                  req_q;
  logic [pzl_pkg::FleetW-1:0]  fleet_q;
  logic [pzl_pkg::ZoneW-1:0]   zone_q, zone_d;
  logic [CB-1:0]               px_q, py_q;
  logic [pzl_pkg::CntW-1:0]    n_q, n_d;
  logic                        en_q;
  logic [pzl_pkg::CntW-1:0]    vidx_q, vidx_d;

  // memories
  logic                         vtx_we, vtx_re;
  logic [pzl_pkg::VAddrW-1:0]   vtx_waddr, vtx_raddr;
  logic [2*CB-1:0]              vtx_rdata;
  logic                         zrd;
  logic                         info_we;
  logic [pzl_pkg::SlotW-1:0]    slot_rd;
  logic [pzl_pkg::InfoW-1:0]    info_rdata;
  logic [2*CB-1:0]              cen_rdata;
  logic [(1 << pzl_pkg::SlotW)-1:0] valid_q;
  logic                         vld_rd_q;

  // centroid datapath
  logic [pzl_pkg::SumW-1:0]  sx_q, sx_d, sy_q, sy_d;
  logic [pzl_pkg::SumW-1:0]  num_q, num_d;
  logic [pzl_pkg::CntW-1:0]  rem_q, rem_d;
  logic [pzl_pkg::CntW-1:0]  dcnt_q, dcnt_d;
  logic                      div_y_q, div_y_d;
  logic [CB-1:0]             cx_q, cx_d, cy_q, cy_d;
  logic [pzl_pkg::CntW:0]    div_r;
  logic                      div_ge;

  // edge datapath
  logic [CB-1:0]  fx_q, fx_d, fy_q, fy_d, prx_q, prx_d, pry_q, pry_d;
  logic [CB-1:0]  ex1_q, ex1_d, ey1_q, ey1_d, ex2_q, ex2_d, ey2_q, ey2_d;
  logic           close_q, close_d;
  logic           cond_q, vert_q, up_q;
  logic signed [pzl_pkg::DiffW-1:0] da_q, db_q, dc_q, dd_q;
  logic signed [pzl_pkg::ProdW-1:0] p1_q, p2_q;
  logic           cond_e2_q, vert_e2_q, up_e2_q;
  logic           hit;
  logic           par_q, par_d;
  logic [CB-1:0]  ylo, yhi, xhi;

  // nearest datapath
  logic [CB-1:0]              dx_q, dy_q;
  logic [pzl_pkg::SqW-1:0]    sqx_q, sqy_q;
  logic [pzl_pkg::DistW-1:0]  dist_sum, best_q, best_d;
  logic                       have_q, have_d;
  logic [pzl_pkg::ZoneW-1:0]  bestz_q, bestz_d;

  logic [pzl_pkg::ZoneW-1:0]  res_d;
  logic                       fnd_d, res_ld;
  logic [CB-1:0]              vx, vy, ccx, ccy;

  assign accept = start && !busy;
  assign busy   = (state_q != pzl_pkg::S_IDLE);
  assign done_o = (state_q == pzl_pkg::S_DONE);

  assign vx  = vtx_rdata[CB-1:0];
  assign vy  = vtx_rdata[2*CB-1:CB];
  assign ccx = cen_rdata[CB-1:0];
  assign ccy = cen_rdata[2*CB-1:CB];

  // ---------------- memories ----------------
  assign vtx_we    = accept && (req_type_i == pzl_pkg::REQ_VTX_WR);
  assign vtx_waddr = {fleet_sel_i, zone_sel_i, vertex_sel_i};
  assign vtx_re    = (state_q == pzl_pkg::S_SUM_RD) || (state_q == pzl_pkg::S_VRD);
  assign vtx_raddr = {fleet_q, zone_q, vidx_q[pzl_pkg::VtxW-1:0]};

  pzl_ram #(.Width(2 * CB), .Depth(1 << pzl_pkg::VAddrW)) u_vtx_ram (
    .clk_i   (clk_i),
    .we_i    (vtx_we),
    .waddr_i (vtx_waddr),
    .wdata_i ({coord_y_i, coord_x_i}),
    .re_i    (vtx_re),
    .raddr_i (vtx_raddr),
    .rdata_o (vtx_rdata)
  );

  assign zrd     = (state_q == pzl_pkg::S_ZRD);
  assign info_we = (state_q == pzl_pkg::S_CWR);
  assign slot_rd = {fleet_q, zone_q};

  pzl_ram #(.Width(pzl_pkg::InfoW), .Depth(1 << pzl_pkg::SlotW)) u_info_ram (
    .clk_i   (clk_i),
    .we_i    (info_we),
    .waddr_i (slot_rd),
    .wdata_i ({en_q, n_q}),
    .re_i    (zrd),
    .raddr_i (slot_rd),
    .rdata_o (info_rdata)
  );

  pzl_ram #(.Width(2 * CB), .Depth(1 << pzl_pkg::SlotW)) u_cen_ram (
    .clk_i   (clk_i),
    .we_i    (info_we),
    .waddr_i (slot_rd),
    .wdata_i ({cy_q, cx_q}),
    .re_i    (zrd),
    .raddr_i (slot_rd),
    .rdata_o (cen_rdata)
  );

  // zone entries never set read as absent, count 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      if (info_we) begin
        valid_q[slot_rd] <= 1'b1;
      end
      if (zrd) begin
        vld_rd_q <= valid_q[slot_rd];
      end
    end
  end

  // ---------------- divider step ----------------
  assign div_r  = {rem_q, num_q[pzl_pkg::SumW-1]};
  assign div_ge = (div_r >= {1'b0, n_q});

  // ---------------- edge test ----------------
  assign ylo = (ey1_q < ey2_q) ? ey1_q : ey2_q;
  assign yhi = (ey1_q < ey2_q) ? ey2_q : ey1_q;
  assign xhi = (ex1_q < ex2_q) ? ex2_q : ex1_q;
  assign hit = cond_e2_q && (vert_e2_q || (up_e2_q ? (p1_q <= p2_q) : (p1_q >= p2_q)));

  assign dist_sum = {1'b0, sqx_q} + {1'b0, sqy_q};

  always_ff @(posedge clk_i) begin
    cond_q <= (ey1_q != ey2_q) && (py_q > ylo) && (py_q <= yhi) && (px_q <= xhi);
    vert_q <= (ex1_q == ex2_q);
    up_q   <= (ey2_q > ey1_q);
    da_q   <= $signed({1'b0, px_q}) - $signed({1'b0, ex1_q});
    db_q   <= $signed({1'b0, ey2_q}) - $signed({1'b0, ey1_q});
    dc_q   <= $signed({1'b0, py_q}) - $signed({1'b0, ey1_q});
    dd_q   <= $signed({1'b0, ex2_q}) - $signed({1'b0, ex1_q});
    p1_q   <= da_q * db_q;
    p2_q   <= dc_q * dd_q;
    cond_e2_q <= cond_q;
    vert_e2_q <= vert_q;
    up_e2_q   <= up_q;
    dx_q  <= (px_q >= ccx) ? px_q - ccx : ccx - px_q;
    dy_q  <= (py_q >= ccy) ? py_q - ccy : ccy - py_q;
    sqx_q <= dx_q * dx_q;
    sqy_q <= dy_q * dy_q;
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    zone_d  = zone_q;
    n_d     = n_q;
    vidx_d  = vidx_q;
    sx_d    = sx_q;
    sy_d    = sy_q;
    num_d   = num_q;
    rem_d   = rem_q;
    dcnt_d  = dcnt_q;
    div_y_d = div_y_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    fx_d    = fx_q;
    fy_d    = fy_q;
    prx_d   = prx_q;
    pry_d   = pry_q;
    ex1_d   = ex1_q;
    ey1_d   = ey1_q;
    ex2_d   = ex2_q;
    ey2_d   = ey2_q;
    close_d = close_q;
    par_d   = par_q;
    best_d  = best_q;
    have_d  = have_q;
    bestz_d = bestz_q;
    res_d   = '0;
    fnd_d   = 1'b0;
    res_ld  = 1'b0;

    case (state_q)
      pzl_pkg::S_IDLE: begin
        if (accept) begin
          zone_d  = zone_sel_i;
          vidx_d  = '0;
          sx_d    = '0;
          sy_d    = '0;
          have_d  = 1'b0;
          bestz_d = '0;
          best_d  = '0;
          n_d     = (vertex_total_i > pzl_pkg::CntW'(pzl_pkg::MaxPoints))
                    ? pzl_pkg::CntW'(pzl_pkg::MaxPoints) : vertex_total_i;
          case (req_type_i)
            pzl_pkg::REQ_VTX_WR: begin
              res_ld  = 1'b1;
              state_d = pzl_pkg::S_DONE;
            end
            pzl_pkg::REQ_SET: state_d = pzl_pkg::S_SUM_RD;
            default: begin
              zone_d  = pzl_pkg::ZoneW'(1);
              state_d = pzl_pkg::S_ZRD;
            end
          endcase
        end
      end

      pzl_pkg::S_SUM_RD: begin
        if (vidx_q == n_q) begin
          if (n_q == '0) begin
            cx_d    = '0;
            cy_d    = '0;
            state_d = pzl_pkg::S_CWR;
          end else begin
            num_d   = sx_q;
            rem_d   = '0;
            dcnt_d  = '0;
            div_y_d = 1'b0;
            state_d = pzl_pkg::S_DIV;
          end
        end else begin
          state_d = pzl_pkg::S_SUM_ACC;
        end
      end

      pzl_pkg::S_SUM_ACC: begin
        sx_d    = sx_q + pzl_pkg::SumW'(vx);
        sy_d    = sy_q + pzl_pkg::SumW'(vy);
        vidx_d  = vidx_q + 1'b1;
        state_d = pzl_pkg::S_SUM_RD;
      end

      pzl_pkg::S_DIV: begin
        // restoring division, one quotient bit a cycle
        rem_d  = div_ge ? pzl_pkg::CntW'(div_r - {1'b0, n_q}) : div_r[pzl_pkg::CntW-1:0];
        num_d  = {num_q[pzl_pkg::SumW-2:0], div_ge};
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == pzl_pkg::CntW'(pzl_pkg::SumW - 1)) begin
          if (!div_y_q) begin
            cx_d    = num_d[CB-1:0];
            num_d   = sy_q;
            rem_d   = '0;
            dcnt_d  = '0;
            div_y_d = 1'b1;
          end else begin
            cy_d    = num_d[CB-1:0];
            state_d = pzl_pkg::S_CWR;
          end
        end
      end

      pzl_pkg::S_CWR: begin
        res_ld  = 1'b1;
        state_d = pzl_pkg::S_DONE;
      end

      pzl_pkg::S_ZRD: state_d = pzl_pkg::S_ZCHK;

      pzl_pkg::S_ZCHK: begin
        n_d = vld_rd_q ? info_rdata[pzl_pkg::CntW-1:0] : '0;
        if (vld_rd_q && info_rdata[pzl_pkg::CntW] && req_q == pzl_pkg::REQ_NEAR) begin
          state_d = pzl_pkg::S_NSQ;
        end else if (vld_rd_q && info_rdata[pzl_pkg::CntW] && req_q == pzl_pkg::REQ_INSIDE
                     && info_rdata[pzl_pkg::CntW-1:0] > pzl_pkg::CntW'(1)) begin
          vidx_d  = '0;
          par_d   = 1'b0;
          close_d = 1'b0;
          state_d = pzl_pkg::S_VRD;
        end else if (zone_q == pzl_pkg::ZoneW'(pzl_pkg::Zones - 1)) begin
          res_ld  = 1'b1;
          res_d   = bestz_q;
          fnd_d   = have_q;
          state_d = pzl_pkg::S_DONE;
        end else begin
          zone_d  = zone_q + 1'b1;
          state_d = pzl_pkg::S_ZRD;
        end
      end

      pzl_pkg::S_VRD: state_d = pzl_pkg::S_VGET;

      pzl_pkg::S_VGET: begin
        vidx_d = vidx_q + 1'b1;
        prx_d  = vx;
        pry_d  = vy;
        if (vidx_q == '0) begin
          fx_d    = vx;
          fy_d    = vy;
          state_d = pzl_pkg::S_VRD;
        end else begin
          ex1_d   = prx_q;
          ey1_d   = pry_q;
          ex2_d   = vx;
          ey2_d   = vy;
          state_d = pzl_pkg::S_E1;
        end
      end

      pzl_pkg::S_E1: state_d = pzl_pkg::S_E2;
      pzl_pkg::S_E2: state_d = pzl_pkg::S_E3;

      pzl_pkg::S_E3: begin
        par_d = par_q ^ hit;
        if (close_q) begin
          if (par_d) begin
            res_ld  = 1'b1;
            res_d   = zone_q;
            fnd_d   = 1'b1;
            state_d = pzl_pkg::S_DONE;
          end else if (zone_q == pzl_pkg::ZoneW'(pzl_pkg::Zones - 1)) begin
            res_ld  = 1'b1;
            state_d = pzl_pkg::S_DONE;
          end else begin
            zone_d  = zone_q + 1'b1;
            state_d = pzl_pkg::S_ZRD;
          end
        end else if (vidx_q == n_q) begin
          // closing edge: last vertex back to the first
          ex1_d   = prx_q;
          ey1_d   = pry_q;
          ex2_d   = fx_q;
          ey2_d   = fy_q;
          close_d = 1'b1;
          state_d = pzl_pkg::S_E1;
        end else begin
          state_d = pzl_pkg::S_VRD;
        end
      end

      pzl_pkg::S_NSQ: state_d = pzl_pkg::S_NCMP;

      pzl_pkg::S_NCMP: begin
        if (!have_q || dist_sum < best_q) begin
          have_d  = 1'b1;
          best_d  = dist_sum;
          bestz_d = zone_q;
        end
        if (zone_q == pzl_pkg::ZoneW'(pzl_pkg::Zones - 1)) begin
          res_ld  = 1'b1;
          res_d   = bestz_d;
          fnd_d   = have_d;
          state_d = pzl_pkg::S_DONE;
        end else begin
          zone_d  = zone_q + 1'b1;
          state_d = pzl_pkg::S_ZRD;
        end
      end

      pzl_pkg::S_DONE: state_d = pzl_pkg::S_IDLE;

      default: state_d = pzl_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pzl_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q   <= req_type_i;
      fleet_q <= fleet_sel_i;
      px_q    <= coord_x_i;
      py_q    <= coord_y_i;
      en_q    <= zone_enable_i;
    end
    zone_q  <= zone_d;
    n_q     <= n_d;
    vidx_q  <= vidx_d;
    sx_q    <= sx_d;
    sy_q    <= sy_d;
    num_q   <= num_d;
    rem_q   <= rem_d;
    dcnt_q  <= dcnt_d;
    div_y_q <= div_y_d;
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    fx_q    <= fx_d;
    fy_q    <= fy_d;
    prx_q   <= prx_d;
    pry_q   <= pry_d;
    ex1_q   <= ex1_d;
    ey1_q   <= ey1_d;
    ex2_q   <= ex2_d;
    ey2_q   <= ey2_d;
    close_q <= close_d;
    par_q   <= par_d;
    best_q  <= best_d;
    have_q  <= have_d;
    bestz_q <= bestz_d;
    if (res_ld) begin
      zone_result_o <= res_d;
      found_o       <= fnd_d;
    end
  end

endmodule

// ===== hw/rtl/pzl_ram.sv =====
module pzl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hw/rtl/pzl_checker.sv =====
`include "polygon_zone_locator_top_defines.svh"

module pzl_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic [4:0] zone_result_o,
  input logic       found_o
);

  // a result word only leaves while an item is in flight
  `PZL_ASSERT_NOW(a_done_busy, clk_i, rst_ni, done_o, busy, "done without busy")
  `PZL_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "accept not held")
  `PZL_ASSERT_NEXT(a_done_free, clk_i, rst_ni, done_o, !busy && !done_o, "done not final")
  `PZL_ASSERT_NOW(a_found_zone, clk_i, rst_ni, done_o, found_o == (zone_result_o != 5'd0),
                  "found disagrees with zone")

endmodule

bind polygon_zone_locator_top pzl_checker u_pzl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .zone_result_o (zone_result_o),
  .found_o       (found_o)
);

// ===== test/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pzl_pkg::*;

  localparam int unsigned CycleLimit = 20_000_000;
  localparam int unsigned RandItems  = 1050;

  typedef struct {
    req_e       req;
    bit [2:0]   fleet;
    bit [4:0]   zone;
    bit [3:0]   vtx;
    bit [23:0]  x;
    bit [23:0]  y;
    bit [4:0]   total;
    bit         en;
  } zone_cmd_t;

  typedef struct {
    zone_cmd_t  cmd;
    bit         known;
    bit [4:0]   zone_exp;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  req_type_i = '0;
  logic [2:0]  fleet_sel_i = '0;
  logic [4:0]  zone_sel_i = '0;
  logic [3:0]  vertex_sel_i = '0;
  logic [23:0] coord_x_i = '0;
  logic [23:0] coord_y_i = '0;
  logic [4:0]  vertex_total_i = '0;
  logic        zone_enable_i = 1'b0;
  logic        done_o;
  logic [4:0]  zone_result_o;
  logic        found_o;

  polygon_zone_locator_top dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // local copy of the zone tables
  bit [23:0] vx_tbl [Fleets][Zones][MaxPoints];
  bit [23:0] vy_tbl [Fleets][Zones][MaxPoints];
  bit        vwritten [Fleets][Zones][MaxPoints];
  bit [4:0]  vcount [Fleets][Zones];
  bit        present [Fleets][Zones];
  bit [23:0] cen_x [Fleets][Zones];
  bit [23:0] cen_y [Fleets][Zones];

  bit [4:0]  zone_results_due [$];
  stim_row_t rows [$];
  int        errors = 0;
  longint    cycles = 0;

  function automatic bit point_inside(int f, int z, longint px, longint py);
    int     n = vcount[f][z];
    int     k;
    bit     odd = 1'b0;
    bit     hit;
    longint x1, y1, x2, y2, ylo, yhi, xhi, lhs, rhs;
    for (int i = 0; i < n; i++) begin
      k = (i == n - 1) ? 0 : i + 1;
      x1 = vx_tbl[f][z][i]; y1 = vy_tbl[f][z][i];
      x2 = vx_tbl[f][z][k]; y2 = vy_tbl[f][z][k];
      ylo = (y1 < y2) ? y1 : y2;
      yhi = (y1 < y2) ? y2 : y1;
      xhi = (x1 < x2) ? x2 : x1;
      if (py > ylo && py <= yhi && px <= xhi && y1 != y2) begin
        if (x1 == x2) hit = 1'b1;
        else begin
          lhs = (px - x1) * (y2 - y1);
          rhs = (py - y1) * (x2 - x1);
          hit = (y2 > y1) ? (lhs <= rhs) : (lhs >= rhs);
        end
        if (hit) odd = ~odd;
      end
    end
    return odd;
  endfunction

  // updates the tables and returns the zone the block should report
  function automatic bit [4:0] locate_zone(zone_cmd_t c);
    int        f = c.fleet;
    int        z = c.zone;
    int        n;
    longint    sx, sy, dx, dy, d, best;
    bit        have = 1'b0;
    bit [4:0]  res = '0;
    case (c.req)
      REQ_VTX_WR: begin
        vx_tbl[f][z][c.vtx] = c.x;
        vy_tbl[f][z][c.vtx] = c.y;
        vwritten[f][z][c.vtx] = 1'b1;
      end
      REQ_SET: begin
        n = (c.total > MaxPoints) ? MaxPoints : c.total;
        sx = 0; sy = 0;
        for (int i = 0; i < n; i++) begin
          sx += vx_tbl[f][z][i];
          sy += vy_tbl[f][z][i];
        end
        vcount[f][z] = 5'(n);
        present[f][z] = c.en;
        cen_x[f][z] = 24'(n ? sx / n : 0);
        cen_y[f][z] = 24'(n ? sy / n : 0);
      end
      REQ_INSIDE: begin
        for (int j = 1; j < Zones; j++)
          if (res == 0 && present[f][j] && point_inside(f, j, c.x, c.y)) res = 5'(j);
      end
      default: begin
        for (int j = 1; j < Zones; j++) begin
          if (present[f][j]) begin
            dx = longint'(c.x) - longint'(cen_x[f][j]);
            dy = longint'(c.y) - longint'(cen_y[f][j]);
            d = dx * dx + dy * dy;
            if (!have || d < best) begin
              have = 1'b1;
              best = d;
              res = 5'(j);
            end
          end
        end
      end
    endcase
    return res;
  endfunction

  // longest run of written vertices from position 0
  function automatic int written_prefix(int f, int z);
    int n = 0;
    while (n < MaxPoints && vwritten[f][z][n]) n++;
    return n;
  endfunction

  task automatic issue_word(zone_cmd_t c, bit known, bit [4:0] zone_exp);
    bit [4:0] pred;
    req_type_i     <= c.req;
    fleet_sel_i    <= c.fleet;
    zone_sel_i     <= c.zone;
    vertex_sel_i   <= c.vtx;
    coord_x_i      <= c.x;
    coord_y_i      <= c.y;
    vertex_total_i <= c.total;
    zone_enable_i  <= c.en;
    start          <= 1'b1;
    do @(posedge clk_i); while (busy);
    pred = locate_zone(c);
    zone_results_due.push_back(known ? zone_exp : pred);
  endtask

  int burst_left = 0;

  task automatic send_word(zone_cmd_t c);
    issue_word(c, 1'b0, '0);
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 12);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  endtask

  function automatic zone_cmd_t mk(req_e r, int f, int z, int v, int x, int y, int t, bit e);
    zone_cmd_t c;
    c.req = r; c.fleet = 3'(f); c.zone = 5'(z); c.vtx = 4'(v);
    c.x = 24'(x); c.y = 24'(y); c.total = 5'(t); c.en = e;
    return c;
  endfunction

  function automatic void add_row(zone_cmd_t c, bit known, int ez);
    stim_row_t r;
    r.cmd = c; r.known = known; r.zone_exp = 5'(ez);
    rows.push_back(r);
  endfunction

  // result side: one word per done_o, no back-pressure possible
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (zone_results_due.size() == 0) begin
        $display("%0t: unexpected word zone=%0d found=%0b", $realtime, zone_result_o, found_o);
        errors++;
      end else begin
        bit [4:0] ez;
        ez = zone_results_due.pop_front();
        if (zone_result_o !== ez) begin
          $display("%0t: zone_result expected %0d actual %0d", $realtime, ez, zone_result_o);
          errors++;
        end
        if (found_o !== (ez != 0)) begin
          $display("%0t: found expected %0b actual %0b", $realtime, ez != 0, found_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int        sent = 0;
    int        f, z, n, k, sel;
    int        bx = 0, by = 0, span = 1000;
    int        lf = 0, lz = 1;
    zone_cmd_t c;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(mk(REQ_NEAR,   0, 0, 0, 0, 0, 0, 0), 1, 0);
    add_row(mk(REQ_INSIDE, 0, 0, 0, 5, 5, 0, 0), 1, 0);
    add_row(mk(REQ_VTX_WR, 0, 1, 0, 0, 0, 0, 0), 1, 0);
    add_row(mk(REQ_VTX_WR, 0, 1, 1, 24'hFFFFFF, 0, 0, 0), 1, 0);
    add_row(mk(REQ_VTX_WR, 0, 1, 2, 0, 24'hFFFFFF, 0, 0), 1, 0);
    add_row(mk(REQ_SET,    0, 1, 0, 0, 0, 3, 1), 1, 0);
    add_row(mk(REQ_INSIDE, 0, 0, 0, 1, 1, 0, 0), 1, 1);
    add_row(mk(REQ_INSIDE, 0, 0, 0, 24'hFFFFFF, 24'hFFFFFF, 0, 0), 1, 0);
    add_row(mk(REQ_INSIDE, 0, 0, 0, 0, 0, 0, 0), 0, 0);
    add_row(mk(REQ_NEAR,   0, 0, 0, 24'hFFFFFF, 24'hFFFFFF, 0, 0), 1, 1);
    // enabled zone with no vertices: never contains, still nearest candidate
    add_row(mk(REQ_SET,    0, 2, 0, 0, 0, 0, 1), 1, 0);
    add_row(mk(REQ_NEAR,   0, 0, 0, 0, 0, 0, 0), 0, 0);
    add_row(mk(REQ_INSIDE, 0, 0, 0, 1, 1, 0, 0), 1, 1);
    // zone 0 is loadable but never searched
    add_row(mk(REQ_VTX_WR, 7, 0, 15, 24'hFFFFFF, 24'hFFFFFF, 0, 1), 1, 0);
    add_row(mk(REQ_SET,    7, 0, 0, 0, 0, 0, 1), 1, 0);
    add_row(mk(REQ_NEAR,   7, 0, 0, 0, 0, 0, 0), 1, 0);
    add_row(mk(REQ_SET,    0, 1, 0, 0, 0, 3, 0), 1, 0);
    add_row(mk(REQ_INSIDE, 0, 0, 0, 1, 1, 0, 0), 1, 0);
    // vertex rewritten after the count: centroid held until the next set
    add_row(mk(REQ_VTX_WR, 0, 1, 0, 3, 3, 0, 0), 1, 0);
    add_row(mk(REQ_NEAR,   0, 0, 0, 24'hFFFFFF, 0, 0, 0), 0, 0);
    add_row(mk(REQ_SET,    0, 1, 0, 0, 0, 3, 1), 1, 0);
    add_row(mk(REQ_NEAR,   0, 0, 0, 24'hFFFFFF, 0, 0, 0), 0, 0);
    add_row(mk(REQ_INSIDE, 0, 0, 0, 2, 2, 0, 0), 0, 0);

    foreach (rows[i]) issue_word(rows[i].cmd, rows[i].known, rows[i].zone_exp);

    while (sent < RandItems) begin
      sel = $urandom_range(0, 9);
      f = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 1);
      if (sel <= 3) begin
        // polygon load: vertices then count/enable
        z = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 31);
        n = ($urandom_range(0, 7) == 0) ? 16 : $urandom_range(3, 6);
        case ($urandom_range(0, 3))
          0: span = 24'hFFFFFF;
          1: span = 65535;
          default: span = 200;
        endcase
        bx = $urandom_range(0, 24'hFFFFFF - span);
        by = $urandom_range(0, 24'hFFFFFF - span);
        for (int v = 0; v < n; v++) begin
          c = mk(REQ_VTX_WR, f, z, v, bx + $urandom_range(0, span),
                 by + $urandom_range(0, span), $urandom_range(0, 31), $urandom_range(0, 1));
          send_word(c);
          sent++;
        end
        k = (n == 16) ? $urandom_range(16, 31) : n;
        c = mk(REQ_SET, f, z, $urandom_range(0, 15), $urandom, $urandom, k,
               $urandom_range(0, 4) != 0);
        send_word(c);
        sent++;
        lf = f; lz = z;
      end else if (sel == 4) begin
        // recount or disable a zone from its written vertices only
        z = $urandom_range(0, 31);
        k = written_prefix(f, z);
        n = $urandom_range(0, k);
        if (n == 16) n = $urandom_range(16, 31);
        c = mk(REQ_SET, f, z, $urandom_range(0, 15), $urandom, $urandom, n,
               $urandom_range(0, 2) != 0);
        send_word(c);
        sent++;
      end else begin
        if ($urandom_range(0, 1) == 0) f = lf;
        case ($urandom_range(0, 4))
          0: c = mk(REQ_INSIDE, f, 0, 0, $urandom, $urandom, 0, 0);
          1: begin
            k = $urandom_range(0, MaxPoints - 1);
            c = mk(REQ_INSIDE, f, 0, 0, vx_tbl[lf][lz][k], vy_tbl[lf][lz][k], 0, 0);
          end
          default: c = mk(REQ_INSIDE, f, 0, 0, bx + $urandom_range(0, span),
                          by + $urandom_range(0, span), 0, 0);
        endcase
        if (sel >= 8) c.req = REQ_NEAR;
        c.zone = 5'($urandom); c.vtx = 4'($urandom); c.total = 5'($urandom);
        c.en = 1'($urandom);
        send_word(c);
        sent++;
      end
    end

    start <= 1'b0;
    while (zone_results_due.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/pzl_pkg.sv
hw/rtl/pzl_ram.sv
hw/rtl/polygon_zone_locator_top.sv
hw/rtl/pzl_checker.sv
test/testbench.sv
